FILE: sv/intensity_ramp_blender_assert.svh
// assertion macros used by the checker file
`ifndef INTENSITY_RAMP_BLENDER_ASSERT_SVH
`define INTENSITY_RAMP_BLENDER_ASSERT_SVH

// clocked assertion, muted while reset is high
`define IRB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define IRB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/irb_pkg.sv
// types, constants and helpers of the intensity ramp blender
package irb_pkg;

   localparam int DW = 32;
   localparam int FW = 16;
   localparam int W1 = DW + 1;
   localparam int W2 = 2 * DW;
   localparam int PW = DW + FW + 2;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOW_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HIGH_LEVEL  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BASE_IS_LOW = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BLEND_MODE  = 2'd3;

   localparam logic signed [DW-1:0] LOW_LEVEL_RESET  = DW'(0);
   localparam logic signed [DW-1:0] HIGH_LEVEL_RESET = DW'(65536);

   typedef enum logic [2:0] {
      MODE_REPLACE  = 3'd0,
      MODE_ADD      = 3'd1,
      MODE_SUBTRACT = 3'd2,
      MODE_MULTIPLY = 3'd3,
      MODE_DIVIDE   = 3'd4
   } blend_mode_type;

   typedef struct packed {
      logic signed [DW-1:0] light_sum;
      logic signed [DW-1:0] base_value;
      logic signed [DW-1:0] alt_value;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] blended_value;
      logic                 saturated;
   } rsp_type;

   // carried alongside the ratio divider
   typedef struct packed {
      logic                 at_low;
      logic                 at_high;
      logic signed [DW-1:0] primary;
      logic signed [DW-1:0] scaled;
      logic signed [DW-1:0] base;
   } ratio_side_type;

   // carried alongside the quotient divider
   typedef struct packed {
      logic                 is_div;
      logic                 m_pos;
      logic                 p_neg;
      logic signed [DW-1:0] res;
      logic                 sat;
   } div_side_type;

   typedef struct packed {
      logic                 sat;
      logic signed [DW-1:0] value;
   } clamp_type;

   function automatic clamp_type sat_clamp(input logic signed [W2-1:0] x);
      logic signed [W2-1:0] max_v;
      logic signed [W2-1:0] min_v;
      clamp_type            r;
      max_v = {{(DW+1){1'b0}}, {(DW-1){1'b1}}};
      min_v = {{(DW+1){1'b1}}, {(DW-1){1'b0}}};
      if (x > max_v) begin
         r.sat   = 1'b1;
         r.value = max_v[DW-1:0];
      end else if (x < min_v) begin
         r.sat   = 1'b1;
         r.value = min_v[DW-1:0];
      end else begin
         r.sat   = 1'b0;
         r.value = x[DW-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/irb_udiv.sv
// pipelined restoring divider, one quotient bit per stage
module irb_udiv import irb_pkg::*; #(
   parameter int RW    = W1,
   parameter int STEPS = FW,
   parameter int SW    = $bits(ratio_side_type)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [RW-1:0]    in_rem,
   input  logic [STEPS-1:0] in_bits,
   input  logic [RW-1:0]    in_div,
   input  logic [SW-1:0]    in_side,
   output logic             out_valid,
   output logic [STEPS-1:0] out_quo,
   output logic [SW-1:0]    out_side
);

   logic             valid_ff [STEPS];
   logic [RW-1:0]    rem_ff   [STEPS];
   logic [RW-1:0]    div_ff   [STEPS];
   logic [STEPS-1:0] bits_ff  [STEPS];
   logic [STEPS-1:0] quo_ff   [STEPS];
   logic [SW-1:0]    side_ff  [STEPS];

   genvar k;
   for (k = 0; k < STEPS; k++) begin : g_step
      logic             prev_valid;
      logic [RW-1:0]    prev_rem;
      logic [RW-1:0]    prev_div;
      logic [STEPS-1:0] prev_bits;
      logic [STEPS-1:0] prev_quo;
      logic [SW-1:0]    prev_side;
      logic [RW:0]      rem2;
      logic [RW:0]      diff;
      logic             ge;
      logic [RW-1:0]    rem_in;
      logic [STEPS-1:0] quo_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = in_rem;
         assign prev_div   = in_div;
         assign prev_bits  = in_bits;
         assign prev_quo   = '0;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_div   = div_ff[k-1];
         assign prev_bits  = bits_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
         assign prev_side  = side_ff[k-1];
      end

      assign rem2   = {prev_rem, prev_bits[STEPS-1]};
      assign diff   = rem2 - {1'b0, prev_div};
      assign ge     = rem2 >= {1'b0, prev_div};
      assign rem_in = ge ? diff[RW-1:0] : rem2[RW-1:0];
      assign quo_in = {prev_quo[STEPS-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            div_ff[k]  <= prev_div;
            bits_ff[k] <= {prev_bits[STEPS-2:0], 1'b0};
            quo_ff[k]  <= quo_in;
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

FILE: sv/irb_blend.sv
// ratio to products, mode results and divide operands, four stages
module irb_blend import irb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [FW-1:0]        in_quo,
   input  ratio_side_type       in_side,
   input  logic [2:0]           mode,
   output logic                 out_valid,
   output logic [DW+FW-1:0]     out_dividend,
   output logic [DW-1:0]        out_divisor,
   output div_side_type         out_side
);

   localparam logic [FW:0] ONE = {1'b1, {FW{1'b0}}};

   // stage 1: ratio and the two ramp products
   logic                 v1_ff;
   logic [FW:0]          ratio;
   logic signed [PW-1:0] sr_in, pr_in, sr_ff, pr_ff;
   logic signed [DW-1:0] p1_ff, b1_ff;

   always_comb begin
      if (in_side.at_low) begin
         ratio = '0;
      end else if (in_side.at_high) begin
         ratio = ONE;
      end else begin
         ratio = {1'b0, in_quo};
      end
   end

   assign sr_in = in_side.scaled * $signed({1'b0, ratio});
   assign pr_in = in_side.primary * $signed({1'b0, ONE - ratio});

   // stage 2: floor back to q16.16
   logic                 v2_ff;
   logic signed [PW-1:0] mix_sum, mix_shift, m_shift;
   logic signed [DW-1:0] m2_ff, rep2_ff, p2_ff, b2_ff;

   assign mix_sum   = sr_ff + pr_ff;
   assign mix_shift = mix_sum >>> FW;
   assign m_shift   = sr_ff >>> FW;

   // stage 3: primary against m
   logic                 v3_ff;
   logic signed [W2-1:0] pm_in, add_in, sub_in, pm_ff, add_ff, sub_ff;
   logic signed [DW-1:0] m3_ff, rep3_ff, p3_ff, b3_ff;

   assign pm_in  = W2'(p2_ff) * W2'(m2_ff);
   assign add_in = W2'(p2_ff) + W2'(m2_ff);
   assign sub_in = W2'(p2_ff) - W2'(m2_ff);

   // stage 4: mode select and divide operands
   logic                 v4_ff;
   logic signed [W2-1:0] pm_shift;
   clamp_type            cl;
   div_side_type         side_in, side_ff;
   logic [DW-1:0]        mag;
   logic [DW+FW-1:0]     dividend_in, dividend_ff;
   logic [DW-1:0]        divisor_ff;

   assign pm_shift = pm_ff >>> FW;
   assign mag      = p3_ff[DW-1] ? DW'(-p3_ff) : DW'(p3_ff);
   assign dividend_in = {mag, {FW{1'b0}}};

   always_comb begin
      side_in.is_div = (mode == MODE_DIVIDE);
      side_in.m_pos  = !m3_ff[DW-1] && (m3_ff != '0);
      side_in.p_neg  = p3_ff[DW-1];
      side_in.res    = b3_ff;
      side_in.sat    = 1'b0;
      cl             = sat_clamp(add_ff);
      case (mode)
         MODE_REPLACE: begin
            side_in.res = rep3_ff;
         end
         MODE_ADD: begin
            cl          = sat_clamp(add_ff);
            side_in.res = cl.value;
            side_in.sat = cl.sat;
         end
         MODE_SUBTRACT: begin
            cl          = sat_clamp(sub_ff);
            side_in.res = cl.value;
            side_in.sat = cl.sat;
         end
         MODE_MULTIPLY: begin
            cl          = sat_clamp(pm_shift);
            side_in.res = cl.value;
            side_in.sat = cl.sat;
         end
         default: begin
            side_in.res = b3_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff       <= sr_in;
         pr_ff       <= pr_in;
         p1_ff       <= in_side.primary;
         b1_ff       <= in_side.base;
         m2_ff       <= m_shift[DW-1:0];
         rep2_ff     <= mix_shift[DW-1:0];
         p2_ff       <= p1_ff;
         b2_ff       <= b1_ff;
         pm_ff       <= pm_in;
         add_ff      <= add_in;
         sub_ff      <= sub_in;
         m3_ff       <= m2_ff;
         rep3_ff     <= rep2_ff;
         p3_ff       <= p2_ff;
         b3_ff       <= b2_ff;
         side_ff     <= side_in;
         dividend_ff <= dividend_in;
         divisor_ff  <= m3_ff;
      end
   end

   assign out_valid    = v4_ff;
   assign out_dividend = dividend_ff;
   assign out_divisor  = divisor_ff;
   assign out_side     = side_ff;

endmodule

FILE: sv/intensity_ramp_blender.sv
// throughput: one transaction per cycle; the whole pipeline holds while rsp is stalled
// depth is set by the bit-serial dividers: 16 ratio stages and 48 quotient stages
// reset: synchronous, clears all valid bits and loads the register defaults
// (low 0, high 1.0, base at the low end, replace mode)
module intensity_ramp_blender import irb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // input transactions
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   // result transactions
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   // register writes
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DW-1:0]              csr_write_data
);

   // configuration registers
   logic signed [DW-1:0] low_level_ff;
   logic signed [DW-1:0] high_level_ff;
   logic                 base_is_low_ff;
   logic [2:0]           blend_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_level_ff   <= LOW_LEVEL_RESET;
         high_level_ff  <= HIGH_LEVEL_RESET;
         base_is_low_ff <= 1'b1;
         blend_mode_ff  <= MODE_REPLACE;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LOW_LEVEL:   low_level_ff   <= csr_write_data;
            REG_HIGH_LEVEL:  high_level_ff  <= csr_write_data;
            REG_BASE_IS_LOW: base_is_low_ff <= csr_write_data[0];
            REG_BLEND_MODE:  blend_mode_ff  <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // one shared advance enable: every stage moves unless the output is held
   logic en;
   assign req_stall = rsp_valid && rsp_stall;
   assign en        = !req_stall;

   // ramp front end: distance into the ramp and its span
   logic signed [W1-1:0] num, den;
   ratio_side_type       rside_in, rside_out;
   logic                 r_valid;
   logic [FW-1:0]        r_quo;

   assign num = W1'(req_data.light_sum) - W1'(low_level_ff);
   assign den = W1'(high_level_ff) - W1'(low_level_ff);

   always_comb begin
      // at_low wins, which also covers an inverted or empty ramp
      rside_in.at_low  = req_data.light_sum <= low_level_ff;
      rside_in.at_high = req_data.light_sum >= high_level_ff;
      rside_in.primary = base_is_low_ff ? req_data.base_value : req_data.alt_value;
      rside_in.scaled  = base_is_low_ff ? req_data.alt_value : req_data.base_value;
      rside_in.base    = req_data.base_value;
   end

   // ratio = num / den as a pure fraction, valid when num < den
   irb_udiv #(
      .RW    (W1),
      .STEPS (FW),
      .SW    ($bits(ratio_side_type))
   ) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_rem    (num),
      .in_bits   ('0),
      .in_div    (den),
      .in_side   (rside_in),
      .out_valid (r_valid),
      .out_quo   (r_quo),
      .out_side  (rside_out)
   );

   // products, non-divide modes and divide operands
   logic                 b_valid;
   logic [DW+FW-1:0]     dividend;
   logic [DW-1:0]        divisor;
   div_side_type         dside_in, dside_out;
   logic                 d_valid;
   logic [DW+FW-1:0]     d_quo;

   irb_blend u_blend (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (r_valid),
      .in_quo       (r_quo),
      .in_side      (rside_out),
      .mode         (blend_mode_ff),
      .out_valid    (b_valid),
      .out_dividend (dividend),
      .out_divisor  (divisor),
      .out_side     (dside_in)
   );

   // |p| * 2^16 / m on magnitudes, sign restored afterward (truncates toward zero)
   irb_udiv #(
      .RW    (DW),
      .STEPS (DW + FW),
      .SW    ($bits(div_side_type))
   ) u_quot_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid),
      .in_rem    ('0),
      .in_bits   (dividend),
      .in_div    (divisor),
      .in_side   (dside_in),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_side  (dside_out)
   );

   // final select and output register
   logic signed [W2-1:0] qext, qsigned;
   clamp_type            qcl;
   rsp_type              rsp_in, rsp_data_ff;
   logic                 rsp_valid_ff;

   assign qext    = W2'(d_quo);
   assign qsigned = dside_out.p_neg ? -qext : qext;
   assign qcl     = sat_clamp(qsigned);

   always_comb begin
      if (!dside_out.is_div) begin
         rsp_in.blended_value = dside_out.res;
         rsp_in.saturated     = dside_out.sat;
      end else if (dside_out.m_pos) begin
         rsp_in.blended_value = qcl.value;
         rsp_in.saturated     = qcl.sat;
      end else begin
         // divisor at or below zero
         rsp_in.blended_value = '0;
         rsp_in.saturated     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/irb_checker.sv
// port-level checks of the intensity ramp blender and their bind
`include "intensity_ramp_blender_assert.svh"

module irb_checker import irb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a clamped result can only sit at one end of the range
   logic at_extreme;
   logic rsp_clamped;
   logic rsp_waiting;

   assign at_extreme  = rsp_data.blended_value == {1'b0, {(DW-1){1'b1}}}
                     || rsp_data.blended_value == {1'b1, {(DW-1){1'b0}}};
   assign rsp_clamped = rsp_valid && rsp_data.saturated;
   assign rsp_waiting = rsp_valid && rsp_stall;

   `IRB_ASSERT(a_rsp_hold, rsp_waiting |=> rsp_valid && $stable(rsp_data), "stalled result changed")
   `IRB_ASSERT(a_no_stall, !rsp_stall |-> !req_stall, "input stalled while output drains")
   `IRB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid right after reset")
   `IRB_ASSERT(a_sat_extreme, rsp_clamped |-> at_extreme, "clamp flag on inner value")

endmodule

bind intensity_ramp_blender irb_checker u_irb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
